@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/lmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer package
// Beat types, register codes, reset values and pattern tables.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  localparam logic [2:0] LEVEL_MAX = 3'd4;
  localparam logic [2:0] LEVEL_CAP = 3'd4;

  localparam logic [7:0] PWM_PERIOD_RST   = 8'd80;
  localparam logic [9:0] FIRST_DELAY_RST  = 10'd25;
  localparam logic [9:0] REPEAT_DELAY_RST = 10'd500;
  localparam logic [9:0] SHOW_TIME_RST    = 10'd500;
  localparam logic [7:0] ROW_RST          = 8'hFF;
  localparam logic [2:0] LEVEL_RST        = 3'd2;
  localparam logic [6:0] COMPARE_RST      = 7'd35;

  localparam logic [7:0] BAR_ON  = 8'hF8;
  localparam logic [7:0] BAR_OFF = 8'h7F;
  localparam logic [7:0] BLANK   = 8'hFF;

  typedef enum logic [1:0] {
    CFG_PWM_PERIOD   = 2'd0,
    CFG_FIRST_DELAY  = 2'd1,
    CFG_REPEAT_DELAY = 2'd2,
    CFG_SHOW_TIME    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic down_pressed;
    logic up_pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] column_drive;
    logic [7:0] row_data;
    logic [2:0] level_now;
    logic       bar_shown;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic [9:0] first_delay;
    logic [9:0] repeat_delay;
    logic [9:0] show_time;
  } cfg_t;

  function automatic logic [7:0] logo_row(input logic [2:0] col);
    logic [7:0] row;
    case (col)
      3'd0:    row = 8'hF8;
      3'd1:    row = 8'hF7;
      3'd2:    row = 8'hF6;
      3'd3:    row = 8'hF5;
      3'd4:    row = 8'hF4;
      3'd5:    row = 8'hF3;
      3'd6:    row = 8'hF2;
      default: row = 8'hF1;
    endcase
    return row;
  endfunction

  function automatic logic [6:0] level_compare(input logic [2:0] lvl);
    logic [6:0] cmp;
    case (lvl)
      3'd0:    cmp = 7'd10;
      3'd1:    cmp = 7'd20;
      3'd2:    cmp = 7'd35;
      3'd3:    cmp = 7'd52;
      default: cmp = 7'd72;
    endcase
    return cmp;
  endfunction

endpackage

@@ rtl/core/lmsd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer configuration registers
// Holds period, hold delays and bar display time written over the config port.
// ----------------------------------------------------------------------------
module lmsd_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [9:0]       cfg_data_i,
  output lmsd_pkg::cfg_t   cfg_o
);

  lmsd_pkg::cfg_t cfg_q;
  lmsd_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (lmsd_pkg::cfg_idx_e'(cfg_index_i))
        lmsd_pkg::CFG_PWM_PERIOD:   cfg_d.pwm_period   = cfg_data_i[7:0];
        lmsd_pkg::CFG_FIRST_DELAY:  cfg_d.first_delay  = cfg_data_i;
        lmsd_pkg::CFG_REPEAT_DELAY: cfg_d.repeat_delay = cfg_data_i;
        lmsd_pkg::CFG_SHOW_TIME:    cfg_d.show_time    = cfg_data_i;
        default:                    cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period   <= lmsd_pkg::PWM_PERIOD_RST;
      cfg_q.first_delay  <= lmsd_pkg::FIRST_DELAY_RST;
      cfg_q.repeat_delay <= lmsd_pkg::REPEAT_DELAY_RST;
      cfg_q.show_time    <= lmsd_pkg::SHOW_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/lmsd_scan_core.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer state update
// Tick counter, column scan, PWM blanking and button level control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmsd_scan_core #(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmsd_pkg::cfg_t       cfg_i,
  input  logic                 step_i,
  input  lmsd_pkg::in_item_t   item_i,
  output lmsd_pkg::out_item_t  result_o
);

  localparam int unsigned COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

  logic [7:0]       tick_q, tick_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             lit_q, lit_d;
  logic [7:0]       row_q, row_d;
  logic [2:0]       level_q, level_d;
  logic [6:0]       cmp_q, cmp_d;
  logic             pend_q, pend_d;
  logic [9:0]       hold_q, hold_d;
  logic [9:0]       show_q, show_d;
  logic             bar_q, bar_d;

  logic [2:0]       col_idx;
  logic [2:0]       capped;
  logic [7:0]       pattern;
  logic             wrap;
  logic             any_btn;
  logic [COL_W-1:0] lit_col;

  always_comb begin
    col_idx = 3'(col_q);
    capped  = (level_q > lmsd_pkg::LEVEL_CAP) ? lmsd_pkg::LEVEL_CAP : level_q;
    if (!bar_q) begin
      pattern = lmsd_pkg::logo_row(col_idx);
    end else if (col_idx < 3'd2 || col_idx > 3'd5) begin
      pattern = lmsd_pkg::BLANK;
    end else if (({1'b0, col_idx} + {1'b0, capped}) >= 4'd6) begin
      pattern = lmsd_pkg::BAR_ON;
    end else begin
      pattern = lmsd_pkg::BAR_OFF;
    end

    wrap    = tick_q >= cfg_i.pwm_period;
    any_btn = item_i.down_pressed | item_i.up_pressed;

    tick_d  = tick_q;
    col_d   = col_q;
    lit_d   = lit_q;
    row_d   = row_q;
    level_d = level_q;
    cmp_d   = cmp_q;
    pend_d  = pend_q;
    hold_d  = hold_q;
    show_d  = show_q;
    bar_d   = bar_q;

    if (wrap) begin
      tick_d = 8'd0;
      row_d  = pattern;
      lit_d  = 1'b1;
      col_d  = (col_q >= LAST_COL) ? '0 : col_q + 1'b1;
      if (pend_q) begin
        cmp_d  = lmsd_pkg::level_compare(capped);
        pend_d = 1'b0;
      end
      if (any_btn) begin
        if (hold_q <= 10'd1) begin
          if (item_i.down_pressed) begin
            if (level_q != 3'd0) begin
              level_d = level_q - 3'd1;
            end
          end else if (level_q < lmsd_pkg::LEVEL_MAX) begin
            level_d = level_q + 3'd1;
          end
          hold_d = cfg_i.repeat_delay;
          bar_d  = 1'b1;
          show_d = cfg_i.show_time;
          pend_d = 1'b1;
        end else begin
          hold_d = hold_q - 10'd1;
        end
      end else begin
        hold_d = cfg_i.first_delay;
        if (bar_q) begin
          if (show_q <= 10'd1) begin
            bar_d  = 1'b0;
            show_d = cfg_i.show_time;
          end else begin
            show_d = show_q - 10'd1;
          end
        end
      end
    end else begin
      tick_d = tick_q + 8'd1;
      if (tick_d == {1'b0, cmp_q}) begin
        lit_d = 1'b0;
      end
    end

    lit_col = (col_d == '0) ? LAST_COL : col_d - 1'b1;
    result_o.column_drive = lit_d ? ~(8'd1 << 3'(lit_col)) : lmsd_pkg::BLANK;
    result_o.row_data     = row_d;
    result_o.level_now    = level_d;
    result_o.bar_shown    = bar_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= 8'd0;
      col_q   <= '0;
      lit_q   <= 1'b0;
      row_q   <= lmsd_pkg::ROW_RST;
      level_q <= lmsd_pkg::LEVEL_RST;
      cmp_q   <= lmsd_pkg::COMPARE_RST;
      pend_q  <= 1'b0;
      hold_q  <= lmsd_pkg::FIRST_DELAY_RST;
      show_q  <= lmsd_pkg::SHOW_TIME_RST;
      bar_q   <= 1'b0;
    end else if (step_i) begin
      tick_q  <= tick_d;
      col_q   <= col_d;
      lit_q   <= lit_d;
      row_q   <= row_d;
      level_q <= level_d;
      cmp_q   <= cmp_d;
      pend_q  <= pend_d;
      hold_q  <= hold_d;
      show_q  <= show_d;
      bar_q   <= bar_d;
    end
  end

  `ASSERT_CHK(a_one_column_low, !step_i || $onehot0(~result_o.column_drive), "two columns low")
  `ASSERT_CHK(a_level_range, level_q <= lmsd_pkg::LEVEL_MAX, "level out of range")
  `ASSERT_NEXT(a_level_shows_bar, step_i && (level_d != level_q), bar_q, "level moved, no bar")

endmodule

@@ rtl/core/led_matrix_scan_dimmer_top.sv @@
// ----------------------------------------------------------------------------
// LED matrix scan dimmer
// Multiplexed column scan with PWM dimming and two-button level control.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick carrying the two button levels; each tick
// yields exactly one output beat with column drive, row byte, level and bar
// flag. One beat is accepted per clock unless the pipeline stalls: the state
// update is combinational logic between the input register and the result
// register, which takes each tick's result; the pipeline stalls only when the
// result register is full and not taken. Configuration writes are taken in
// any cycle and must be made while no tick is in flight.
module led_matrix_scan_dimmer_top #(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lmsd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lmsd_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [9:0]           cfg_data_i
);

  lmsd_pkg::cfg_t      cfg;
  lmsd_pkg::out_item_t result;
  lmsd_pkg::in_item_t  in_q, in_d;
  lmsd_pkg::out_item_t out_q, out_d;
  logic                in_vld_q, in_vld_d;
  logic                out_vld_q, out_vld_d;
  logic                advance;

  lmsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lmsd_scan_core #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_comb begin
    advance    = in_vld_q && (!out_vld_q || out_ready_i);
    in_ready_o = !in_vld_q || advance;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
    in_d  = (in_valid_i && in_ready_o) ? in_data_i : in_q;
    out_d = advance ? result : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan dimmer testbench
// Drives timer ticks with button levels through random idle gaps and output
// stalls, predicts column drive, row byte, level and bar flag for every tick,
// and compares each output beat in order. Register settings change between
// drained phases, from zero periods and delays up to the largest values.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;

  localparam lmsd_pkg::in_item_t NO_KEY    = '{down_pressed: 1'b0, up_pressed: 1'b0};
  localparam lmsd_pkg::in_item_t UP_KEY    = '{down_pressed: 1'b0, up_pressed: 1'b1};
  localparam lmsd_pkg::in_item_t DOWN_KEY  = '{down_pressed: 1'b1, up_pressed: 1'b0};
  localparam lmsd_pkg::in_item_t BOTH_KEYS = '{down_pressed: 1'b1, up_pressed: 1'b1};

  class dimmer_scoreboard;
    lmsd_pkg::out_item_t pending_drives[$];
    int         errors;
    logic [7:0] logo_rows[8];
    logic [6:0] compare_tab[5];
    logic [7:0] period;
    logic [9:0] first_dly;
    logic [9:0] repeat_dly;
    logic [9:0] show_len;
    logic [7:0] tick;
    int         scan_col;
    logic       lit;
    logic [7:0] row;
    logic [2:0] level;
    logic [6:0] cmp;
    logic       cmp_pend;
    logic [9:0] hold;
    logic [9:0] show;
    logic       bar;

    function new();
      logo_rows   = '{8'hF8, 8'hF7, 8'hF6, 8'hF5, 8'hF4, 8'hF3, 8'hF2, 8'hF1};
      compare_tab = '{7'd10, 7'd20, 7'd35, 7'd52, 7'd72};
      errors     = 0;
      period     = 8'd80;
      first_dly  = 10'd25;
      repeat_dly = 10'd500;
      show_len   = 10'd500;
      tick       = 8'd0;
      scan_col   = 0;
      lit        = 1'b0;
      row        = 8'hFF;
      level      = 3'd2;
      cmp        = 7'd35;
      cmp_pend   = 1'b0;
      hold       = 10'd25;
      show       = 10'd500;
      bar        = 1'b0;
    endfunction

    function int capped();
      return (level > 3'd4) ? 4 : int'(level);
    endfunction

    function void write_reg(lmsd_pkg::cfg_idx_e idx, logic [9:0] val);
      case (idx)
        lmsd_pkg::CFG_PWM_PERIOD:   period     = val[7:0];
        lmsd_pkg::CFG_FIRST_DELAY:  first_dly  = val;
        lmsd_pkg::CFG_REPEAT_DELAY: repeat_dly = val;
        lmsd_pkg::CFG_SHOW_TIME:    show_len   = val;
        default: ;
      endcase
    endfunction

    function void note_tick(lmsd_pkg::in_item_t t);
      lmsd_pkg::out_item_t res;
      int        lit_col;
      if (tick >= period) begin
        tick = 8'd0;
        if (!bar) begin
          row = logo_rows[scan_col];
        end else if (scan_col < 2 || scan_col > 5) begin
          row = lmsd_pkg::BLANK;
        end else begin
          row = (scan_col + capped() >= 6) ? lmsd_pkg::BAR_ON : lmsd_pkg::BAR_OFF;
        end
        lit = 1'b1;
        scan_col = (scan_col + 1 >= 8) ? 0 : scan_col + 1;
        if (cmp_pend) begin
          cmp = compare_tab[capped()];
          cmp_pend = 1'b0;
        end
        if (t.down_pressed || t.up_pressed) begin
          if (hold <= 10'd1) begin
            if (t.down_pressed) begin
              if (level > 3'd0) level = level - 3'd1;
            end else if (level < lmsd_pkg::LEVEL_MAX) begin
              level = level + 3'd1;
            end
            hold     = repeat_dly;
            bar      = 1'b1;
            show     = show_len;
            cmp_pend = 1'b1;
          end else begin
            hold = hold - 10'd1;
          end
        end else begin
          hold = first_dly;
          if (bar) begin
            if (show <= 10'd1) begin
              bar  = 1'b0;
              show = show_len;
            end else begin
              show = show - 10'd1;
            end
          end
        end
      end else begin
        tick = tick + 8'd1;
        if (tick == {1'b0, cmp}) lit = 1'b0;
      end
      lit_col = (scan_col == 0) ? 7 : scan_col - 1;
      res.column_drive = lit ? ~(8'h01 << lit_col) : 8'hFF;
      res.row_data     = row;
      res.level_now    = level;
      res.bar_shown    = bar;
      pending_drives.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_drive(lmsd_pkg::out_item_t got);
      lmsd_pkg::out_item_t want;
      if (pending_drives.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_drives.pop_front();
        if (got.column_drive !== want.column_drive)
          report($sformatf("column_drive %h, want %h", got.column_drive, want.column_drive));
        if (got.row_data !== want.row_data)
          report($sformatf("row_data %h, want %h", got.row_data, want.row_data));
        if (got.level_now !== want.level_now)
          report($sformatf("level_now %0d, want %0d", got.level_now, want.level_now));
        if (got.bar_shown !== want.bar_shown)
          report($sformatf("bar_shown %b, want %b", got.bar_shown, want.bar_shown));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  lmsd_pkg::in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  lmsd_pkg::out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  dimmer_scoreboard sb;
  bit idle_on;
  int cycles;

  led_matrix_scan_dimmer_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_drive(out_data_o);
  end

  initial begin
    int gap;
    out_ready_i = 1'b0;
    forever begin
      gap = idle_on ? $urandom_range(0, 11) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_ready_i <= 1'b0;
      end
      @(negedge clk);
      out_ready_i <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  task send_tick(lmsd_pkg::in_item_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk); while (!in_ready_o);
    sb.note_tick(t);
  endtask

  task send_random_ticks(int count);
    int       left;
    int       run;
    lmsd_pkg::in_item_t held;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        run = $urandom_range(1, 6);
        if (run > left) run = left;
        repeat (run) send_tick(lmsd_pkg::in_item_t'(2'($urandom_range(0, 3))));
      end else begin
        held = lmsd_pkg::in_item_t'(2'($urandom_range(0, 3)));
        run  = $urandom_range(1, 30);
        if (run > left) run = left;
        repeat (run) send_tick(held);
      end
      left -= run;
    end
  endtask

  task drain_results(int hold_cycles);
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk);
    repeat (hold_cycles) @(posedge clk);
  endtask

  task write_register(lmsd_pkg::cfg_idx_e idx, logic [9:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task apply_settings(logic [7:0] per, logic [9:0] first, logic [9:0] rep, logic [9:0] shw);
    logic [1:0] upper;
    upper = 2'($urandom_range(0, 3));
    write_register(lmsd_pkg::CFG_PWM_PERIOD, {upper, per});
    write_register(lmsd_pkg::CFG_FIRST_DELAY, first);
    write_register(lmsd_pkg::CFG_REPEAT_DELAY, rep);
    write_register(lmsd_pkg::CFG_SHOW_TIME, shw);
  endtask

  initial begin
    sb          = new();
    idle_on     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = NO_KEY;
    cfg_valid_i = 1'b0;
    cfg_index_i = lmsd_pkg::CFG_PWM_PERIOD;
    cfg_data_i  = 10'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    send_tick(NO_KEY);
    send_tick(UP_KEY);
    send_tick(DOWN_KEY);
    send_tick(BOTH_KEYS);
    drain_results(4);

    apply_settings(8'd0, 10'd0, 10'd1, 10'd1);
    send_tick(NO_KEY);
    repeat (4) send_tick(UP_KEY);
    send_tick(BOTH_KEYS);
    repeat (4) send_tick(DOWN_KEY);
    repeat (3) send_tick(NO_KEY);
    send_tick(UP_KEY);
    send_tick(NO_KEY);
    drain_results(4);

    for (int p = 0; p < 12; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (p)
        0: begin
          apply_settings(8'd255, 10'd1023, 10'd1023, 10'd1023);
          send_random_ticks(60);
        end
        1: begin
          apply_settings(8'd0, 10'd0, 10'd0, 10'd0);
          send_random_ticks(100);
        end
        4: begin
          apply_settings(8'($urandom_range(70, 90)), 10'd1,
                         10'($urandom_range(1, 3)), 10'd2);
          send_random_ticks(200);
        end
        6: begin
          apply_settings(8'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                         10'($urandom_range(0, 6)), 10'($urandom_range(0, 10)));
          send_random_ticks(44);
          drain_results(0);
          send_random_ticks(44);
        end
        default: begin
          apply_settings(8'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                         10'($urandom_range(0, 6)), 10'($urandom_range(0, 10)));
          send_random_ticks(88);
        end
      endcase
      drain_results(4);
    end

    drain_results(8);
    if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
